### src/fdacc_pkg.sv
package fdacc_pkg;

    localparam int PIXELS      = 65536;
    localparam int PIX_W       = $clog2(PIXELS);
    localparam int MAX_WINDOW  = 16;
    localparam int RING_DEPTH  = MAX_WINDOW - 1;
    localparam int HIST_DEPTH  = PIXELS * RING_DEPTH;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int WIN_W       = 5;
    localparam int SLOT_W      = $clog2(RING_DEPTH);
    localparam int GRAY_W      = 8;
    localparam int SUM_W       = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIN_W-1:0] WIN_RESET    = WIN_W'(10);
    localparam logic [WIN_W-1:0] WIN_MIN      = WIN_W'(2);
    localparam logic [WIN_W-1:0] WIN_MAX      = WIN_W'(MAX_WINDOW);
    localparam logic [SUM_W-1:0] THRESH_RESET = SUM_W'(100);
    localparam logic [SUM_W-1:0] SUM_MAX      = SUM_W'(255);

    typedef enum logic [1:0] {
        MODE_FIRST,
        MODE_FILL,
        MODE_FULL
    } mode_t;

    typedef enum logic {
        REG_WINDOW    = 1'b0,
        REG_THRESHOLD = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [GRAY_W-1:0]  gray;
        logic [PIX_W-1:0]   pix;
        logic [HIST_AW-1:0] haddr;
        mode_t              mode;
    } item_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

endpackage

### src/fdacc_ram.sv
module fdacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/fdacc_front.sv
module fdacc_front import fdacc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,     // [7:0] gray, [23:8] pixel_index
    input  logic              s_tlast,     // end_of_frame
    input  logic [WIN_W-1:0]  window_frames,
    output q_wr_t             q_wr,        // push out, full in
    input  logic              q_full,
    output item_t             push_item
);

    logic [WIN_W-1:0]  frames_held_reg, frames_held_next;
    logic [SLOT_W-1:0] history_slot_reg, history_slot_next;
    logic [WIN_W-1:0]  win;
    logic [SLOT_W-1:0] slot;
    logic [WIN_W-1:0]  slot_inc;
    logic [GRAY_W-1:0] gray;
    logic [PIX_W-1:0]  pix;
    logic              push;

    assign gray     = s_tdata[GRAY_W-1:0];
    assign pix      = s_tdata[GRAY_W +: PIX_W];
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign q_wr.push = push;
    assign q_wr.full = q_full;

    always_comb
    begin
        if (window_frames < WIN_MIN)
        begin
            win = WIN_MIN;
        end
        else if (window_frames > WIN_MAX)
        begin
            win = WIN_MAX;
        end
        else
        begin
            win = window_frames;
        end
    end

    assign slot = (history_slot_reg >= SLOT_W'(RING_DEPTH)) ? '0 : history_slot_reg;

    always_comb
    begin
        push_item.gray  = gray;
        push_item.pix   = pix;
        push_item.haddr = HIST_AW'(pix) * HIST_AW'(RING_DEPTH) + HIST_AW'(slot);
        if (frames_held_reg == '0)
        begin
            push_item.mode = MODE_FIRST;
        end
        else if (frames_held_reg >= win)
        begin
            push_item.mode = MODE_FULL;
        end
        else
        begin
            push_item.mode = MODE_FILL;
        end
    end

    // frame counter and shared ring slot advance on the last pixel of a frame
    assign slot_inc = WIN_W'(history_slot_reg) + WIN_W'(1);

    always_comb
    begin
        frames_held_next  = frames_held_reg;
        history_slot_next = history_slot_reg;
        if (push && s_tlast)
        begin
            if (frames_held_reg != '0)
            begin
                history_slot_next = (slot_inc >= win - WIN_W'(1)) ? '0
                                                                  : slot_inc[SLOT_W-1:0];
            end
            if (frames_held_reg < win)
            begin
                frames_held_next = frames_held_reg + WIN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_held_reg  <= '0;
            history_slot_reg <= '0;
        end
        else
        begin
            frames_held_reg  <= frames_held_next;
            history_slot_reg <= history_slot_next;
        end
    end

endmodule

### src/fdacc_queue.sv
module fdacc_queue import fdacc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  q_wr_t q_wr,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = q_wr.push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(q_wr.push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.full |-> !q_wr.push)
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty queue");

endmodule

### src/fdacc_back.sv
module fdacc_back import fdacc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  item_t             head_item,
    output logic              pop,
    input  logic [SUM_W-1:0]  motion_threshold,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,     // [7:0] window_sum, [8] motion
    output logic              m_tuser      // motion_valid
);

    // read stage: item whose memory reads are in flight / registered
    logic               s1_valid_reg, s1_valid_next;
    item_t              s1_item_reg;
    logic               fwd_pix_reg, fwd_hist_reg;

    // last values written, for a read that collided with that write
    logic [GRAY_W-1:0]  lw_gray_reg;
    logic [SUM_W-1:0]   lw_sum_reg;
    logic [GRAY_W-1:0]  lw_diff_reg;

    logic               out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]   out_sum_reg;
    logic               out_motion_reg;
    logic               out_mvalid_reg;

    logic               issue, s1_advance;
    logic [GRAY_W-1:0]  prev_rd, hist_rd, prev, old;
    logic [SUM_W-1:0]   sum_rd, sum_old, base, sat_sum, new_sum;
    logic [GRAY_W-1:0]  diff;
    logic [SUM_W:0]     total;
    logic               hist_we;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign issue      = head_valid && (!s1_valid_reg || s1_advance);
    assign pop        = issue;
    assign hist_we    = s1_advance && (s1_item_reg.mode != MODE_FIRST);

    fdacc_ram #(.WIDTH(GRAY_W), .DEPTH(PIXELS)) u_prev_ram (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_item_reg.pix),
        .wdata (s1_item_reg.gray),
        .re    (issue),
        .raddr (head_item.pix),
        .rdata (prev_rd)
    );

    // running sums: pixels of the first frame write zero, which stands in for a clear
    fdacc_ram #(.WIDTH(SUM_W), .DEPTH(PIXELS)) u_sum_ram (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_item_reg.pix),
        .wdata (new_sum),
        .re    (issue),
        .raddr (head_item.pix),
        .rdata (sum_rd)
    );

    fdacc_ram #(.WIDTH(GRAY_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (s1_item_reg.haddr),
        .wdata (diff),
        .re    (issue),
        .raddr (head_item.haddr),
        .rdata (hist_rd)
    );

    always_comb
    begin
        prev    = fwd_pix_reg  ? lw_gray_reg : prev_rd;
        sum_old = fwd_pix_reg  ? lw_sum_reg  : sum_rd;
        old     = fwd_hist_reg ? lw_diff_reg : hist_rd;
        diff    = (s1_item_reg.gray > prev) ? s1_item_reg.gray - prev
                                            : prev - s1_item_reg.gray;
        if (s1_item_reg.mode == MODE_FULL)
        begin
            base = (sum_old > old) ? sum_old - old : '0;
        end
        else
        begin
            base = sum_old;
        end
        total   = {1'b0, base} + {1'b0, diff};
        sat_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
        new_sum = (s1_item_reg.mode == MODE_FIRST) ? '0 : sat_sum;
    end

    always_comb
    begin
        s1_valid_next = issue ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_item_reg  <= head_item;
            fwd_pix_reg  <= s1_advance && (head_item.pix == s1_item_reg.pix);
            fwd_hist_reg <= hist_we && (head_item.haddr == s1_item_reg.haddr);
        end
        if (s1_advance)
        begin
            lw_gray_reg    <= s1_item_reg.gray;
            lw_sum_reg     <= new_sum;
            lw_diff_reg    <= diff;
            out_sum_reg    <= new_sum;
            out_mvalid_reg <= (s1_item_reg.mode == MODE_FULL);
            out_motion_reg <= (s1_item_reg.mode == MODE_FULL) && (new_sum > motion_threshold);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_motion_reg, out_sum_reg};
    assign m_tuser  = out_mvalid_reg;

    a_motion_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_mvalid_reg |-> !out_motion_reg)
        else $error("motion flagged before window full");

    a_no_issue_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |-> !issue)
        else $error("read issued over a stalled item");

    a_hist_fwd_same_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && fwd_hist_reg |-> fwd_pix_reg)
        else $error("history forward without pixel forward");

endmodule

### src/frame_difference_accumulator_unit.sv
// Channel  Dir  Fields (low bit first)                         Handshake
// s_*      in   tdata: gray[7:0], pixel_index[23:8]; tlast     tvalid/tready
//               end_of_frame
// m_*      out  tdata: window_sum[7:0], motion[8]; tuser       tvalid/tready
//               motion_valid
// apb      in   0x0 window_frames[4:0], 0x4 motion_threshold   psel/penable
//
// One pixel per clock sustained while m_tready stays high; an input transaction
// passes through the queue, the read stage and the output register to m_tvalid.
// The rate is set by the read-modify-write on the three pixel memories, one
// read and one write port each, with a forward path for back-to-back pixels.
// Reset clears control state only; no clearing pass: first-frame pixels write
// a zero running sum. A four-entry queue keeps input taken during output stalls.
module frame_difference_accumulator_unit import fdacc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [7:0] gray, [23:8] pixel_index
    input  logic        s_tlast,     // end_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] window_sum, [8] motion
    output logic        m_tuser,     // motion_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [WIN_W-1:0] window_frames_reg, window_frames_next;
    logic [SUM_W-1:0] threshold_reg, threshold_next;
    logic             cfg_write;
    reg_idx_t         cfg_idx;

    q_wr_t            q_wr;
    logic             q_full;
    item_t            push_item;
    logic             head_valid;
    item_t            head_item;
    logic             pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_comb
    begin
        window_frames_next = window_frames_reg;
        threshold_next     = threshold_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_WINDOW:    window_frames_next = pwdata[WIN_W-1:0];
                REG_THRESHOLD: threshold_next     = pwdata[SUM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WINDOW:    prdata = 32'(window_frames_reg);
            REG_THRESHOLD: prdata = 32'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_frames_reg <= WIN_RESET;
            threshold_reg     <= THRESH_RESET;
        end
        else
        begin
            window_frames_reg <= window_frames_next;
            threshold_reg     <= threshold_next;
        end
    end

    fdacc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .window_frames (window_frames_reg),
        .q_wr          (q_wr),
        .q_full        (q_full),
        .push_item     (push_item)
    );

    fdacc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_wr       (q_wr),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    fdacc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head_item        (head_item),
        .pop              (pop),
        .motion_threshold (threshold_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser)
    );

endmodule
